// ----- rtl/core/bufq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bufq_pkg: shared types and constants of the buffered byte queues
// Queue geometry, operation codes and the control structs passed between
// the pointer units and the top level.
// ----------------------------------------------------------------------------
package bufq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int BYTE_W      = 8;

	localparam logic [BYTE_W-1:0] ERROR_MASK_RST = 8'h46;

	typedef enum logic [1:0] {
		OP_HOST_WR  = 2'd0,
		OP_HOST_RD  = 2'd1,
		OP_RX_BYTE  = 2'd2,
		OP_TX_READY = 2'd3
	} opcode_t;

	typedef logic [PTR_W-1:0]   ptr_t;
	typedef logic [LEVEL_W-1:0] level_t;

	// push / pop request into one queue
	typedef struct packed {
		logic push;
		logic pop;
	} q_req_t;

	// outcome of one request, with the addresses to use at the store
	typedef struct packed {
		logic   push_ok;
		logic   pop_ok;
		ptr_t   wr_addr;
		ptr_t   rd_addr;
		level_t fill_next;
	} q_stat_t;

	function automatic ptr_t ptr_advance(ptr_t p);
		ptr_advance = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ----- rtl/core/bufq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bufq_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// register holds while the read enable is low.
// ----------------------------------------------------------------------------
module bufq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/bufq_ptrs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bufq_ptrs: ring pointers and fill count of one byte queue
// Refuses a push when full and a pop when empty; advances head, tail and
// fill in the cycle the request is presented.
// ----------------------------------------------------------------------------
module bufq_ptrs import bufq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_req_t  req,
	output q_stat_t stat
);

	ptr_t   head_q;
	ptr_t   tail_q;
	level_t fill_q;
	logic   full;
	logic   empty;

	assign full  = (fill_q == LEVEL_W'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);

	always_comb begin
		stat.push_ok = req.push && !full;
		stat.pop_ok  = req.pop && !empty;
		stat.wr_addr = head_q;
		stat.rd_addr = tail_q;
		stat.fill_next = fill_q;
		if (stat.push_ok && !stat.pop_ok) begin
			stat.fill_next = fill_q + 1'b1;
		end else if (stat.pop_ok && !stat.push_ok) begin
			stat.fill_next = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (stat.push_ok) begin
				head_q <= ptr_advance(head_q);
			end
			if (stat.pop_ok) begin
				tail_q <= ptr_advance(tail_q);
			end
			fill_q <= stat.fill_next;
		end
	end

endmodule

// ----- rtl/core/buffered_uart_byte_queues.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffered_uart_byte_queues: receive and transmit byte queues of a serial port
// Two ring-buffered byte queues with fill counts, host read/write and
// receiver/transmitter events, one result word per operation.
// ----------------------------------------------------------------------------
// Each input word carries one operation in tuser (host write, host read,
// byte received, transmitter ready) and returns exactly one result word.
// A new word is taken every clock cycle while the result side keeps up. Its
// result word passes through the read stage and the output register: the
// popped byte is read into the registered read port of a RAM at the accept
// edge and is then loaded into the output register. When the result side
// stalls, the read stage and the output register hold one word each before
// tready drops. Queue pointers and fill counts update at the accept edge, so
// back-to-back operations always see the effect of the previous one. A write
// to a full transmit queue and a receive into a full receive queue are
// refused (accepted = 0); a dropped receive sets rx_overflow, which only
// reset clears. error_mask (reset 0x46) selects the status bits reported on
// host reads; write it only while no operation is in flight. Queue contents
// need no clearing after reset.
// ----------------------------------------------------------------------------
module buffered_uart_byte_queues import bufq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,     // error_mask
	// operation words in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [7:0] data_byte, [15:8] rx_status
	input  logic [1:0]  s_axis_tuser,    // [1:0] opcode
	// result words out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata     // [0] accepted, [8:1] read_byte,
	                                     // [16:9] read_status, [17] read_empty,
	                                     // [18] tx_valid, [26:19] tx_byte,
	                                     // [27] tx_irq_enable, [28] rx_overflow,
	                                     // [35:29] rx_level, [42:36] tx_level,
	                                     // [47:43] zero
);

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] read_status;
		logic              read_empty;
		logic              rx_pop;       // read_byte comes from the rx RAM
		logic              tx_pop;       // tx_byte comes from the tx RAM
		logic              tx_irq;
		logic              overflow;
		level_t            rx_level;
		level_t            tx_level;
	} s1_t;

	typedef struct packed {
		logic              accepted;
		logic [BYTE_W-1:0] read_byte;
		logic [BYTE_W-1:0] read_status;
		logic              read_empty;
		logic              tx_valid;
		logic [BYTE_W-1:0] tx_byte;
		logic              tx_irq;
		logic              overflow;
		level_t            rx_level;
		level_t            tx_level;
	} result_t;

	opcode_t           op;
	logic [BYTE_W-1:0] in_byte;
	logic [BYTE_W-1:0] in_status;
	logic              accept;

	logic [BYTE_W-1:0] error_mask_q;
	logic [BYTE_W-1:0] last_status_q;
	logic              tx_irq_q;
	logic              ovf_q;
	logic              tx_irq_next;
	logic              ovf_next;

	q_req_t            rx_req;
	q_req_t            tx_req;
	q_stat_t           rx_stat;
	q_stat_t           tx_stat;
	logic [BYTE_W-1:0] rx_rdata;
	logic [BYTE_W-1:0] tx_rdata;

	logic              s1_valid;
	s1_t               s1_d;
	s1_t               s1_s1;
	logic              s1_move;
	logic              s2_load;
	logic              s2_valid;
	result_t           s2_s2;

	assign op        = opcode_t'(s_axis_tuser);
	assign in_byte   = s_axis_tdata[7:0];
	assign in_status = s_axis_tdata[15:8];

	// Pipeline flow: output register takes a word when empty or draining,
	// the read stage moves when the output register takes it.
	assign s2_load       = !s2_valid || m_axis_tready;
	assign s1_move       = s1_valid && s2_load;
	assign s_axis_tready = !s1_valid || s2_load;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// Decode the operation into queue requests.
	always_comb begin
		rx_req = '0;
		tx_req = '0;
		case (op)
			OP_HOST_WR:  tx_req.push = accept;
			OP_HOST_RD:  rx_req.pop  = accept;
			OP_RX_BYTE:  rx_req.push = accept;
			OP_TX_READY: tx_req.pop  = accept;
			default: begin
				rx_req = '0;
				tx_req = '0;
			end
		endcase
	end

	bufq_ptrs u_rx_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rx_req),
		.stat   (rx_stat)
	);

	bufq_ptrs u_tx_ptrs (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tx_req),
		.stat   (tx_stat)
	);

	// Byte stores: read only on a successful pop so the read register holds
	// its byte while the read stage is stalled.
	bufq_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_stat.push_ok),
		.waddr (rx_stat.wr_addr),
		.wdata (in_byte),
		.re    (rx_stat.pop_ok),
		.raddr (rx_stat.rd_addr),
		.rdata (rx_rdata)
	);

	bufq_ram #(.WIDTH(BYTE_W), .DEPTH(QUEUE_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_stat.push_ok),
		.waddr (tx_stat.wr_addr),
		.wdata (in_byte),
		.re    (tx_stat.pop_ok),
		.raddr (tx_stat.rd_addr),
		.rdata (tx_rdata)
	);

	// Interrupt enable: arm on an accepted host write, drop when the
	// transmitter asks for a byte and none is left.
	always_comb begin
		tx_irq_next = tx_irq_q;
		if (tx_stat.push_ok) begin
			tx_irq_next = 1'b1;
		end else if (tx_req.pop && !tx_stat.pop_ok) begin
			tx_irq_next = 1'b0;
		end
		ovf_next = ovf_q || (rx_req.push && !rx_stat.push_ok);
	end

	always_comb begin
		s1_d.accepted    = rx_stat.push_ok || tx_stat.push_ok;
		s1_d.read_status = (op == OP_HOST_RD) ? (last_status_q & error_mask_q) : '0;
		s1_d.read_empty  = rx_req.pop && !rx_stat.pop_ok;
		s1_d.rx_pop      = rx_stat.pop_ok;
		s1_d.tx_pop      = tx_stat.pop_ok;
		s1_d.tx_irq      = tx_irq_next;
		s1_d.overflow    = ovf_next;
		s1_d.rx_level    = rx_stat.fill_next;
		s1_d.tx_level    = tx_stat.fill_next;
	end

	// Status registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_mask_q  <= ERROR_MASK_RST;
			last_status_q <= '0;
			tx_irq_q      <= 1'b0;
			ovf_q         <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				error_mask_q <= cfg_wr_data;
			end
			if (rx_req.push) begin
				last_status_q <= in_status;   // latched even when the byte drops
			end
			tx_irq_q <= tx_irq_next;
			ovf_q    <= ovf_next;
		end
	end

	// Read stage: hold control results while the RAM read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_s1 <= s1_d;
		end
	end

	// Output register: merge the popped byte into the result word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_load) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			s2_s2.accepted    <= s1_s1.accepted;
			s2_s2.read_byte   <= s1_s1.rx_pop ? rx_rdata : '0;
			s2_s2.read_status <= s1_s1.read_status;
			s2_s2.read_empty  <= s1_s1.read_empty;
			s2_s2.tx_valid    <= s1_s1.tx_pop;
			s2_s2.tx_byte     <= s1_s1.tx_pop ? tx_rdata : '0;
			s2_s2.tx_irq      <= s1_s1.tx_irq;
			s2_s2.overflow    <= s1_s1.overflow;
			s2_s2.rx_level    <= s1_s1.rx_level;
			s2_s2.tx_level    <= s1_s1.tx_level;
		end
	end

	assign m_axis_tvalid = s2_valid;
	assign m_axis_tdata  = {5'b0, 7'(s2_s2.tx_level), 7'(s2_s2.rx_level),
		s2_s2.overflow, s2_s2.tx_irq, s2_s2.tx_byte, s2_s2.tx_valid,
		s2_s2.read_empty, s2_s2.read_status, s2_s2.read_byte, s2_s2.accepted};

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |=> ovf_q)
		else $error("rx overflow flag cleared outside reset");

	a_empty_level: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && s2_s2.read_empty) |-> (s2_s2.rx_level == '0))
		else $error("read reported empty with bytes in the receive queue");

	a_pop_level: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid && s2_s2.tx_valid) |-> (s2_s2.tx_level < LEVEL_W'(QUEUE_DEPTH)))
		else $error("transmit pop left a full queue");

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid |-> !(s2_s2.accepted && (s2_s2.read_empty || s2_s2.tx_valid)))
		else $error("result word carries outcomes of two operations");

	a_irq_on_push: assert property (@(posedge clk) disable iff (!arst_n)
		tx_stat.push_ok |=> tx_irq_q)
		else $error("transmit interrupt not armed after a host write");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the buffered serial port byte queues
// Drives host writes, host reads, received bytes and transmitter-ready events
// under random idling and back-pressure. Every accepted operation word is
// predicted against a local model of both queues, and each result word is
// compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import bufq_pkg::*;

	localparam int PHASES         = 12;
	localparam int PHASE_WORDS    = 152;
	localparam int IDLE_PCT       = 26;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_SLACK    = 4;

	// one predicted result word, unpacked into its fields
	typedef struct {
		logic       accepted;
		logic [7:0] read_byte;
		logic [7:0] read_status;
		logic       read_empty;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_irq_enable;
		logic       rx_overflow;
		level_t     rx_level;
		level_t     tx_level;
	} queue_result_t;

	// Queue predictor plus the ordered store of result words still to come.
	class result_scoreboard;
		logic [7:0]    rx_bytes[$];
		logic [7:0]    tx_bytes[$];
		logic [7:0]    last_status;
		logic [7:0]    error_mask;
		logic          irq_on;
		logic          overflow;
		queue_result_t expected[$];
		int            errors;
		int            checked;
		int            op_count[4];
		int            tx_refused;
		int            rx_dropped;
		int            rd_empty;
		int            tx_empty;

		function new();
			last_status = 8'h00;
			error_mask  = ERROR_MASK_RST;
			irq_on      = 1'b0;
			overflow    = 1'b0;
			errors      = 0;
			checked     = 0;
			tx_refused  = 0;
			rx_dropped  = 0;
			rd_empty    = 0;
			tx_empty    = 0;
			foreach (op_count[i]) op_count[i] = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		// Predict the result of one accepted operation word.
		function void note_word(opcode_t op, logic [7:0] data, logic [7:0] status);
			queue_result_t r;
			r = '{default: '0};
			op_count[op]++;
			case (op)
				OP_HOST_WR: begin
					if (tx_bytes.size() < QUEUE_DEPTH) begin
						tx_bytes.push_back(data);
						r.accepted = 1'b1;
						irq_on = 1'b1;
					end else begin
						tx_refused++;
					end
				end
				OP_HOST_RD: begin
					// the masked status is reported even from an empty queue
					r.read_status = last_status & error_mask;
					if (rx_bytes.size() != 0) begin
						r.read_byte = rx_bytes.pop_front();
					end else begin
						r.read_empty = 1'b1;
						rd_empty++;
					end
				end
				OP_RX_BYTE: begin
					if (rx_bytes.size() < QUEUE_DEPTH) begin
						rx_bytes.push_back(data);
						r.accepted = 1'b1;
					end else begin
						overflow = 1'b1;
						rx_dropped++;
					end
					// status latches even when the byte is dropped
					last_status = status;
				end
				OP_TX_READY: begin
					if (tx_bytes.size() != 0) begin
						r.tx_valid = 1'b1;
						r.tx_byte  = tx_bytes.pop_front();
					end else begin
						irq_on = 1'b0;
						tx_empty++;
					end
				end
			endcase
			r.tx_irq_enable = irq_on;
			r.rx_overflow   = overflow;
			r.rx_level      = level_t'(rx_bytes.size());
			r.tx_level      = level_t'(tx_bytes.size());
			expected.push_back(r);
		endfunction

		function void compare(string name, logic [15:0] exp, logic [15:0] act);
			if (exp !== act) begin
				$display("%0t: mismatch on %s, expected %0h, actual %0h",
					$time, name, exp, act);
				errors++;
			end
		endfunction

		// Compare one result word with the oldest prediction.
		function void check_word(logic [47:0] w);
			queue_result_t e;
			if (expected.size() == 0) begin
				$display("%0t: result word %h with nothing expected, expected none, actual %h",
					$time, w, w);
				errors++;
				return;
			end
			e = expected.pop_front();
			checked++;
			compare("accepted",      e.accepted,      w[0]);
			compare("read_byte",     e.read_byte,     w[8:1]);
			compare("read_status",   e.read_status,   w[16:9]);
			compare("read_empty",    e.read_empty,    w[17]);
			compare("tx_valid",      e.tx_valid,      w[18]);
			compare("tx_byte",       e.tx_byte,       w[26:19]);
			compare("tx_irq_enable", e.tx_irq_enable, w[27]);
			compare("rx_overflow",   e.rx_overflow,   w[28]);
			compare("rx_level",      e.rx_level,      w[35:29]);
			compare("tx_level",      e.tx_level,      w[42:36]);
			compare("padding",       '0,              w[47:43]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic [7:0]  cfg_wr_data   = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = 16'h0000;  // [7:0] data_byte, [15:8] rx_status
	logic [1:0]  s_axis_tuser  = 2'b00;     // [1:0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;              // [0] accepted, [8:1] read_byte,
	                                        // [16:9] read_status, [17] read_empty,
	                                        // [18] tx_valid, [26:19] tx_byte,
	                                        // [27] tx_irq_enable, [28] rx_overflow,
	                                        // [35:29] rx_level, [42:36] tx_level

	result_scoreboard sb = new();

	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	bit holdoff_req = 1'b0;
	int mask_settings = 1;

	buffered_uart_byte_queues dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: check every accepted result word, then pick the next
	// tready. A hold-off request stalls the sink for a long counted stretch.
	always @(posedge clk) begin
		int holdoff_left;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
			if (holdoff_req) begin
				holdoff_req  = 1'b0;
				holdoff_left = HOLDOFF_CYCLES;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !(snk_idle_on && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: abort when no word moves on either side for too long.
	always @(posedge clk) begin
		int quiet;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("%0t: no word moved for %0d cycles, %0d results outstanding",
					$time, quiet, sb.pending());
				$display("buffered_uart_byte_queues verification failed");
				$finish;
			end
		end
	end

	// Offer one operation word, idling at random first; hold until accepted.
	task automatic send_word(opcode_t op, logic [7:0] data, logic [7:0] status);
		while (src_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {status, data};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_word(op, data, status);
	endtask

	// Drop tvalid and hold until every predicted result has come back,
	// then let the pipeline settle.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// Write error_mask; only call with nothing in flight.
	task automatic write_mask(logic [7:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.error_mask = value;
		mask_settings++;
	endtask

	// Random operation word, weighted toward one op for the given phase kind:
	// 0 balanced, 1 fill receive, 2 fill transmit, 3 drain receive,
	// 4 drain transmit.
	task automatic send_random(int kind);
		opcode_t heavy;
		opcode_t op;
		case (kind)
			1:       heavy = OP_RX_BYTE;
			2:       heavy = OP_HOST_WR;
			3:       heavy = OP_HOST_RD;
			4:       heavy = OP_TX_READY;
			default: heavy = OP_HOST_WR;
		endcase
		if (kind != 0 && $urandom_range(0, 99) < 70) begin
			op = heavy;
		end else begin
			op = opcode_t'($urandom_range(0, 3));
		end
		send_word(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [7:0] mask;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset state, empty pops, byte extremes, masked status.
		send_word(OP_HOST_RD,  8'h5A, 8'hFF);   // empty read, status still reported
		send_word(OP_TX_READY, 8'hFF, 8'h00);   // nothing queued, irq stays clear
		send_word(OP_HOST_WR,  8'h00, 8'hFF);
		send_word(OP_HOST_WR,  8'hFF, 8'h00);
		send_word(OP_TX_READY, 8'h00, 8'h00);
		send_word(OP_TX_READY, 8'h00, 8'h00);
		send_word(OP_TX_READY, 8'h00, 8'h00);   // empty again: clear irq
		send_word(OP_RX_BYTE,  8'hFF, 8'hFF);
		send_word(OP_RX_BYTE,  8'h00, 8'h00);
		send_word(OP_RX_BYTE,  8'hA5, 8'h46);
		send_word(OP_HOST_RD,  8'h00, 8'h00);
		send_word(OP_HOST_RD,  8'h00, 8'h00);
		send_word(OP_HOST_RD,  8'h00, 8'h00);
		send_word(OP_HOST_RD,  8'h00, 8'h00);   // empty, masked last status
		send_word(OP_HOST_WR,  8'h3C, 8'hC3);
		send_word(OP_TX_READY, 8'hC3, 8'h3C);

		// Random phases: fill and drain each queue past full and empty,
		// a fresh error_mask before each, extremes included.
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			case (p % 4)
				0:       mask = 8'h00;
				1:       mask = 8'hFF;
				2:       mask = 8'($urandom_range(0, 255));
				default: mask = ERROR_MASK_RST;
			endcase
			write_mask(mask);
			// one long stretch with no idling on either side
			src_idle_on = (p != 4);
			snk_idle_on = (p != 4);
			// stall the sink for a long stretch while words keep coming
			if (p == 6) holdoff_req = 1'b1;
			for (int i = 0; i < PHASE_WORDS; i++) send_random(p % 5);
		end
		src_idle_on = 1'b1;
		snk_idle_on = 1'b1;
		wait_drained();

		$display("Covered %0d host writes (%0d refused full), %0d host reads (%0d empty),",
			sb.op_count[OP_HOST_WR], sb.tx_refused, sb.op_count[OP_HOST_RD], sb.rd_empty);
		$display("%0d receives (%0d dropped), %0d tx-ready (%0d empty); %0d results, %0d masks",
			sb.op_count[OP_RX_BYTE], sb.rx_dropped, sb.op_count[OP_TX_READY], sb.tx_empty,
			sb.checked, mask_settings);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("buffered_uart_byte_queues verification clean");
		end else begin
			$display("buffered_uart_byte_queues verification failed");
		end
		$finish;
	end

endmodule
